FILE: rtl/core/asfe_pkg.sv
// ----------------------------------------------------------------------------
// asfe_pkg
// Shared types, register indexes and format helpers for the serial frame
// engine.
// ----------------------------------------------------------------------------
package asfe_pkg;

  localparam int ShiftW = 12;

  typedef enum logic [1:0] {
    CFG_WORD_BITS   = 2'd0,
    CFG_STOP_BITS   = 2'd1,
    CFG_PARITY_MODE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_ODD  = 2'd1,
    PAR_EVEN = 2'd2
  } parity_t;

  // effective frame format, out-of-range settings already clamped
  typedef struct packed {
    logic [3:0] word;
    logic [1:0] stop;
    logic       par;
    logic       odd;
  } fmt_t;

  function automatic fmt_t eff_fmt(logic [3:0] word_bits, logic [1:0] stop_bits,
                                   logic [1:0] parity_mode);
    fmt_t f;
    if (word_bits < 4'd5) begin
      f.word = 4'd5;
    end else if (word_bits > 4'd8) begin
      f.word = 4'd8;
    end else begin
      f.word = word_bits;
    end
    if (stop_bits == 2'd0) begin
      f.stop = 2'd1;
    end else if (stop_bits == 2'd3) begin
      f.stop = 2'd2;
    end else begin
      f.stop = stop_bits;
    end
    f.par = (parity_mode == PAR_ODD) || (parity_mode == PAR_EVEN);
    f.odd = (parity_mode == PAR_ODD);
    return f;
  endfunction

  function automatic logic [7:0] word_mask(logic [3:0] word);
    return 8'hFF >> (4'd8 - word);
  endfunction

endpackage

FILE: rtl/core/async_serial_frame_engine.sv
// ----------------------------------------------------------------------------
// async_serial_frame_engine
// Tick-driven serial transmitter and receiver with programmable frame format.
// ----------------------------------------------------------------------------
// Each input item is one baud tick: sampled rx_line, clear_to_send and the
// byte to send next. Each item yields exactly one result item: tx_level,
// tx_taken, rx_done and rx_byte.
// The accepting edge loads the input register; the edge on which the item
// advances loads the result register, where the receive and transmit state
// also update. A stalled result holds the item in the input register.
// One item per cycle is sustained while out_stall is low.
// in_stall rises only while the input register holds an item that cannot
// move because the result register is full and out_stall is high; a held
// result stays put until taken.
// Configuration: cfg_index 0 word_bits, 1 stop_bits, 2 parity_mode; index 3
// is ignored. cfg_ready is always high. Write only while no item is in flight.
// Synchronous reset restores 8 data bits, 1 stop, no parity, an idle-high
// transmit line, an empty transmitter and a receiver waiting for a start
// edge, and empties both registers.
// ----------------------------------------------------------------------------
module async_serial_frame_engine import asfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       rx_line,
  input  logic       clear_to_send,
  input  logic [7:0] tx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_level,
  output logic       tx_taken,
  output logic       rx_done,
  output logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  logic [3:0] word_bits;
  logic [1:0] stop_bits;
  logic [1:0] parity_mode;
  fmt_t       fmt;

  logic       in_full;
  logic       in_rx;
  logic       in_cts;
  logic [7:0] in_byte;
  logic       advance;
  logic       accept;

  logic       level_next, taken_next, done_next;
  logic [7:0] byte_next;

  assign cfg_ready = 1'b1;
  assign fmt       = eff_fmt(word_bits, stop_bits, parity_mode);
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits   <= 4'd8;
      stop_bits   <= 2'd1;
      parity_mode <= PAR_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WORD_BITS:   word_bits   <= cfg_data;
        CFG_STOP_BITS:   stop_bits   <= cfg_data[1:0];
        CFG_PARITY_MODE: parity_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_rx   <= rx_line;
      in_cts  <= clear_to_send;
      in_byte <= tx_byte;
    end
  end

  asfe_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .fmt       (fmt),
    .rx_line   (in_rx),
    .done_next (done_next),
    .byte_next (byte_next)
  );

  asfe_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .fmt           (fmt),
    .clear_to_send (in_cts),
    .tx_byte       (in_byte),
    .level_next    (level_next),
    .taken_next    (taken_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_level <= level_next;
      tx_taken <= taken_next;
      rx_done  <= done_next;
      rx_byte  <= byte_next;
    end
  end

  // a held result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !advance)
    else $error("result register overwritten while stalled");

  // every step lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("step did not produce a result");

  // an item that cannot move stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("input item dropped");

  // a latched frame cannot be announced twice in a row
  assert property (@(posedge clk) disable iff (rst)
    advance && taken_next |=> !(advance && taken_next && !$past(in_cts)))
    else $error("transmit frame latched twice without sending");

endmodule

FILE: rtl/core/asfe_rx.sv
// ----------------------------------------------------------------------------
// asfe_rx
// Receive side: start edge detect, bit count and character extraction.
// ----------------------------------------------------------------------------
module asfe_rx import asfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  fmt_t       fmt,
  input  logic       rx_line,
  output logic       done_next,
  output logic [7:0] byte_next
);

  logic [ShiftW-1:0] rx_shift, rx_shift_next;
  logic [3:0]        rx_count, rx_count_next;
  logic              rx_in_frame, rx_in_frame_next;
  logic [7:0]        rx_last_byte;
  logic [3:0]        frame_bits;
  logic [2:0]        tail;
  logic [ShiftW-1:0] data;

  always_comb begin
    tail             = 3'({1'b0, fmt.stop}) + 3'(fmt.par);
    frame_bits       = fmt.word + 4'(tail);
    rx_shift_next    = {rx_shift[ShiftW-2:0], rx_line};
    rx_count_next    = rx_count + 4'd1;
    rx_in_frame_next = rx_in_frame;
    data             = rx_shift_next >> tail;
    done_next        = 1'b0;
    byte_next        = rx_last_byte;
    if (!rx_in_frame) begin
      if (rx_shift[0] && !rx_line) begin
        rx_in_frame_next = 1'b1;
        rx_count_next    = 4'd0;
      end
    end else if (rx_count_next == frame_bits) begin
      byte_next        = data[7:0] & word_mask(fmt.word);
      rx_count_next    = 4'd0;
      rx_in_frame_next = 1'b0;
      done_next        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_shift     <= '0;
      rx_count     <= '0;
      rx_in_frame  <= 1'b0;
      rx_last_byte <= '0;
    end else if (step) begin
      rx_shift     <= rx_shift_next;
      rx_count     <= rx_count_next;
      rx_in_frame  <= rx_in_frame_next;
      rx_last_byte <= byte_next;
    end
  end

endmodule

FILE: rtl/core/asfe_tx.sv
// ----------------------------------------------------------------------------
// asfe_tx
// Transmit side: frame build when empty; one bit per tick with clear_to_send.
// ----------------------------------------------------------------------------
module asfe_tx import asfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  fmt_t       fmt,
  input  logic       clear_to_send,
  input  logic [7:0] tx_byte,
  output logic       level_next,
  output logic       taken_next
);

  logic [ShiftW-1:0] tx_shift, tx_shift_next;
  logic [3:0]        tx_length, tx_length_next;
  logic [3:0]        tx_sent, tx_sent_next;
  logic              tx_empty, tx_empty_next;
  logic              tx_line_reg;
  logic [7:0]        data;
  logic              pbit;
  logic [2:0]        tail;
  logic [ShiftW-1:0] frame;
  logic [3:0]        pos;

  always_comb begin
    data  = tx_byte & word_mask(fmt.word);
    pbit  = (^data) ^ fmt.odd;
    tail  = 3'({1'b0, fmt.stop}) + 3'(fmt.par);
    frame = (ShiftW'(data) << tail)
          | (ShiftW'(pbit & fmt.par) << fmt.stop)
          | ((fmt.stop == 2'd2) ? ShiftW'(3) : ShiftW'(1));

    tx_shift_next  = tx_shift;
    tx_length_next = tx_length;
    tx_sent_next   = tx_sent;
    tx_empty_next  = tx_empty;
    taken_next     = 1'b0;
    if (tx_empty) begin
      tx_shift_next  = frame;
      tx_length_next = 4'd1 + fmt.word + 4'(tail);
      tx_sent_next   = 4'd0;
      tx_empty_next  = 1'b0;
      taken_next     = 1'b1;
    end

    pos        = tx_length_next - 4'd1 - tx_sent_next;
    level_next = tx_line_reg;
    if (clear_to_send && (tx_sent_next < tx_length_next)) begin
      level_next   = (pos < 4'(ShiftW)) ? tx_shift_next[pos] : 1'b0;
      tx_sent_next = tx_sent_next + 4'd1;
      if (tx_sent_next == tx_length_next) begin
        tx_empty_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift    <= '0;
      tx_length   <= '0;
      tx_sent     <= '0;
      tx_empty    <= 1'b1;
      tx_line_reg <= 1'b1;
    end else if (step) begin
      tx_shift    <= tx_shift_next;
      tx_length   <= tx_length_next;
      tx_sent     <= tx_sent_next;
      tx_empty    <= tx_empty_next;
      tx_line_reg <= level_next;
    end
  end

endmodule
